[src/rboa_pkg.sv]
// Package for the radial binned orientation average unit.
// Holds bin geometry, command codes and register indexes; no dependencies.
`default_nettype none
package rboa_pkg;

  localparam int NUM_BINS = 256;
  localparam int BIN_W    = $clog2(NUM_BINS);

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_MAX_DIST = 3'd3;
  localparam logic [2:0] REG_BIN_W    = 3'd4;

  localparam logic [31:0] MAX_DIST_RESET  = 32'd655360;
  localparam logic [31:0] BIN_WIDTH_RESET = 32'd2560;

  // Which computation the shared divider is running.
  typedef enum logic [1:0] {
    DIV_COS = 2'd0,
    DIV_BIN = 2'd1,
    DIV_AVG = 2'd2
  } div_kind_t;

  // Saturates a quotient magnitude to signed Q1.15, negating it when neg is set.
  function automatic logic [15:0] sat_q15(input logic [64:0] q, input logic neg);
    logic [15:0] r;
    if (neg) begin
      r = (q > 65'd32768) ? 16'h8000 : 16'(16'd0 - q[15:0]);
    end else begin
      r = (q > 65'd32767) ? 16'h7fff : q[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/radial_binned_orientation_average_unit.sv]
// Radial binned orientation average unit: top level and only module.
// Depends on rboa_pkg for bin geometry, command codes and the Q1.15 saturation.
// A binned sample runs three square-sum passes, two square roots, a multiply and three
// divider passes; a read runs a divider pass unless its bin is empty, and a clear or a
// sample with directional low goes straight to its result beat. One item at a time; the
// next start is taken during the result beat. Results cannot be stalled.
// Reset (rst, synchronous) restores the registers and marks every bin empty at once.
`default_nettype none
module radial_binned_orientation_average_unit
  import rboa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [15:0] axis_x,
  input  wire logic signed [15:0] axis_y,
  input  wire logic signed [15:0] axis_z,
  input  wire logic               directional,
  input  wire logic [7:0]         read_bin,
  output logic                    done,
  output logic                    accepted,
  output logic [7:0]              bin_index,
  output logic signed [15:0]      cos_angle,
  output logic signed [47:0]      bin_sum,
  output logic [31:0]             bin_count,
  output logic signed [15:0]      bin_average
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOAD    = 4'd1;
  localparam logic [3:0] S_SQ      = 4'd2;
  localparam logic [3:0] S_SQE     = 4'd3;
  localparam logic [3:0] S_SQRT    = 4'd4;
  localparam logic [3:0] S_SQRTEND = 4'd5;
  localparam logic [3:0] S_MUL     = 4'd6;
  localparam logic [3:0] S_MULE    = 4'd7;
  localparam logic [3:0] S_BIN     = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_DIVEND  = 4'd10;
  localparam logic [3:0] S_RD      = 4'd11;
  localparam logic [3:0] S_UPD     = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  // Configuration registers.
  logic signed [31:0] center_x, center_y, center_z;
  logic [31:0] max_distance, bin_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      center_z     <= '0;
      max_distance <= MAX_DIST_RESET;
      bin_width    <= BIN_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_CENTER_Z: center_z <= cfg_data;
        REG_MAX_DIST: max_distance <= cfg_data;
        REG_BIN_W:    bin_width <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0] state;
  logic [6:0] cnt;
  logic [1:0] comp;
  logic       is_read;

  // Per-component magnitudes and signs of r = center - pos and of the axis.
  logic [31:0] rmag [3];
  logic        rneg [3];
  logic [15:0] amag [3];
  logic        aneg [3];

  // Serial square-sum, axis square-sum and dot product.
  logic [63:0]        msh;    // |r| shifted up once per cycle
  logic [31:0]        mbits;  // bits of |r| still to consume
  logic [31:0]        ash;    // |a| shifted up
  logic [47:0]        rsh;    // |r| shifted up for the dot product
  logic [15:0]        abits;
  logic               dneg;
  logic [65:0]        ssq;
  logic [31:0]        asq;
  logic signed [50:0] dot;

  // Square root unit, two radicand bits per cycle.
  logic [67:0] sq_x;
  logic [34:0] sq_rem;
  logic [33:0] sq_root;
  logic        sq_is_d;
  logic [36:0] sq_rem_sh;
  logic [36:0] sq_trial;

  logic [33:0] radius;
  logic [15:0] norm;

  // Serial multiplier for d * n.
  logic [49:0] mcand;
  logic [15:0] mplier;
  logic [49:0] den;

  // Shared restoring divider, one quotient bit per cycle.
  logic [64:0] div_num;
  logic [49:0] div_den;
  logic [49:0] div_rem;
  logic [64:0] div_q;
  logic        div_neg;
  div_kind_t   div_kind;
  logic [50:0] div_rem_sh;

  // Bin store with one valid bit per bin.
  logic [BIN_W-1:0]   addr;
  logic signed [47:0] sum_mem [NUM_BINS];
  logic [31:0]        cnt_mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld;
  logic signed [47:0] rd_sum;
  logic [31:0]        rd_cnt;
  logic               rd_vld;
  logic               mem_we;
  logic signed [47:0] cur_sum, new_sum;
  logic [31:0]        cur_cnt, new_cnt;
  logic               clear_all;

  logic signed [32:0] r_x, r_y, r_z;
  logic [49:0]        dot_mag;
  logic [47:0]        new_mag, cur_mag;

  assign busy = (state != S_IDLE);

  assign r_x = 33'(center_x) - 33'(pos_x);
  assign r_y = 33'(center_y) - 33'(pos_y);
  assign r_z = 33'(center_z) - 33'(pos_z);

  assign sq_rem_sh  = {sq_rem, sq_x[67:66]};
  assign sq_trial   = {1'b0, sq_root, 2'b01};
  assign div_rem_sh = {div_rem, div_num[64]};

  assign cur_sum = rd_vld ? rd_sum : '0;
  assign cur_cnt = rd_vld ? rd_cnt : '0;
  assign new_sum = cur_sum + 48'(cos_angle);
  assign new_cnt = cur_cnt + 32'd1;
  assign new_mag = new_sum[47] ? 48'(-new_sum) : 48'(new_sum);
  assign cur_mag = cur_sum[47] ? 48'(-cur_sum) : 48'(cur_sum);
  assign dot_mag = dot[50] ? 50'(-dot) : 50'(dot);

  // A sample is written back only when the bin count has room.
  assign mem_we    = (state == S_UPD) && !is_read && (cur_cnt != 32'hffff_ffff);
  assign clear_all = (state == S_IDLE) && start && (func == FUNC_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[addr] <= new_sum;
      cnt_mem[addr] <= new_cnt;
    end
    rd_sum <= sum_mem[addr];
    rd_cnt <= cnt_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[addr] <= 1'b1;
      end
      rd_vld <= vld[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            accepted    <= 1'b0;
            bin_index   <= '0;
            cos_angle   <= '0;
            bin_sum     <= '0;
            bin_count   <= '0;
            bin_average <= '0;
            is_read     <= 1'b0;
            rmag[0] <= r_x[32] ? 32'(-r_x) : r_x[31:0];
            rmag[1] <= r_y[32] ? 32'(-r_y) : r_y[31:0];
            rmag[2] <= r_z[32] ? 32'(-r_z) : r_z[31:0];
            rneg[0] <= r_x[32];
            rneg[1] <= r_y[32];
            rneg[2] <= r_z[32];
            amag[0] <= axis_x[15] ? 16'(-axis_x) : axis_x;
            amag[1] <= axis_y[15] ? 16'(-axis_y) : axis_y;
            amag[2] <= axis_z[15] ? 16'(-axis_z) : axis_z;
            aneg[0] <= axis_x[15];
            aneg[1] <= axis_y[15];
            aneg[2] <= axis_z[15];
            ssq  <= '0;
            asq  <= '0;
            dot  <= '0;
            comp <= 2'd0;
            case (func)
              FUNC_SAMPLE: begin
                state <= directional ? S_LOAD : S_OUT;
              end
              FUNC_READ: begin
                is_read <= 1'b1;
                addr    <= BIN_W'(read_bin);
                if (13'(read_bin) < 13'(NUM_BINS)) begin
                  state <= S_RD;
                end else begin
                  bin_index <= read_bin;
                  state     <= S_OUT;
                end
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_LOAD: begin
          msh   <= 64'(rmag[comp]);
          mbits <= rmag[comp];
          rsh   <= 48'(rmag[comp]);
          ash   <= 32'(amag[comp]);
          abits <= amag[comp];
          dneg  <= rneg[comp] ^ aneg[comp];
          cnt   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (mbits[0]) begin
            ssq <= ssq + 66'(msh);
          end
          if (abits[0]) begin
            asq <= asq + ash;
            dot <= dneg ? dot - 51'(rsh) : dot + 51'(rsh);
          end
          msh   <= msh << 1;
          mbits <= mbits >> 1;
          ash   <= ash << 1;
          rsh   <= rsh << 1;
          abits <= abits >> 1;
          cnt   <= cnt + 7'd1;
          if (cnt == 7'd31) begin
            if (comp == 2'd2) begin
              state <= S_SQE;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_LOAD;
            end
          end
        end
        S_SQE: begin
          sq_x    <= 68'(ssq);
          sq_rem  <= '0;
          sq_root <= '0;
          sq_is_d <= 1'b1;
          cnt     <= '0;
          state   <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_rem_sh >= sq_trial) begin
            sq_rem  <= 35'(sq_rem_sh - sq_trial);
            sq_root <= {sq_root[32:0], 1'b1};
          end else begin
            sq_rem  <= sq_rem_sh[34:0];
            sq_root <= {sq_root[32:0], 1'b0};
          end
          sq_x <= sq_x << 2;
          cnt  <= cnt + 7'd1;
          if (cnt == 7'd33) begin
            state <= S_SQRTEND;
          end
        end
        S_SQRTEND: begin
          if (sq_is_d) begin
            radius  <= sq_root;
            sq_x    <= 68'(asq);
            sq_rem  <= '0;
            sq_root <= '0;
            sq_is_d <= 1'b0;
            cnt     <= '0;
            state   <= S_SQRT;
          end else begin
            norm   <= sq_root[15:0];
            mcand  <= 50'(radius);
            mplier <= sq_root[15:0];
            den    <= '0;
            cnt    <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier[0]) begin
            den <= den + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 7'd1;
          if (cnt == 7'd15) begin
            state <= S_MULE;
          end
        end
        S_MULE: begin
          // A zero-length vector or a zero axis leaves the cosine at zero.
          if (den != '0) begin
            div_num  <= {1'b0, dot_mag[48:0], 15'd0} + 65'(den >> 1);
            div_den  <= den;
            div_rem  <= '0;
            div_neg  <= dot[50];
            div_kind <= DIV_COS;
            cnt      <= '0;
            state    <= S_DIV;
          end else begin
            state <= S_BIN;
          end
        end
        S_BIN: begin
          if ((radius < 34'(max_distance)) && (bin_width != '0)) begin
            div_num  <= 65'(radius);
            div_den  <= 50'(bin_width);
            div_rem  <= '0;
            div_neg  <= 1'b0;
            div_kind <= DIV_BIN;
            cnt      <= '0;
            state    <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_rem_sh >= {1'b0, div_den}) begin
            div_rem <= 50'(div_rem_sh - {1'b0, div_den});
            div_q   <= {div_q[63:0], 1'b1};
          end else begin
            div_rem <= div_rem_sh[49:0];
            div_q   <= {div_q[63:0], 1'b0};
          end
          div_num <= div_num << 1;
          cnt     <= cnt + 7'd1;
          if (cnt == 7'd64) begin
            state <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          case (div_kind)
            DIV_COS: begin
              cos_angle <= sat_q15(div_q, div_neg);
              state     <= S_BIN;
            end
            DIV_BIN: begin
              if (div_q < 65'(NUM_BINS)) begin
                addr  <= div_q[BIN_W-1:0];
                state <= S_RD;
              end else begin
                state <= S_OUT;
              end
            end
            default: begin
              bin_average <= sat_q15(div_q, div_neg);
              state       <= S_OUT;
            end
          endcase
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (is_read) begin
            bin_index <= 8'(addr);
            bin_sum   <= cur_sum;
            bin_count <= cur_cnt;
            if (cur_cnt != '0) begin
              div_num  <= 65'(cur_mag) + 65'(cur_cnt >> 1);
              div_den  <= 50'(cur_cnt);
              div_rem  <= '0;
              div_neg  <= cur_sum[47];
              div_kind <= DIV_AVG;
              cnt      <= '0;
              state    <= S_DIV;
            end else begin
              state <= S_OUT;
            end
          end else if (cur_cnt == 32'hffff_ffff) begin
            state <= S_OUT;
          end else begin
            accepted  <= 1'b1;
            bin_index <= 8'(addr);
            bin_sum   <= new_sum;
            bin_count <= new_cnt;
            div_num   <= 65'(new_mag) + 65'(new_cnt >> 1);
            div_den   <= 50'(new_cnt);
            div_rem   <= '0;
            div_neg   <= new_sum[47];
            div_kind  <= DIV_AVG;
            cnt       <= '0;
            state     <= S_DIV;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A zero axis norm must leave the cosine at zero by the time binning starts.
  logic norm_zero;
  assign norm_zero = (norm == '0);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the unit busy");
  a_acc_count: assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> (bin_count != '0))
    else $error("accepted sample reports an empty bin");
  a_norm_cos: assert property (@(posedge clk) disable iff (rst)
    (state == S_BIN && norm_zero) |-> (cos_angle == '0))
    else $error("nonzero cosine with a zero axis");

endmodule
`default_nettype wire
